### design/ahfe_pkg.sv
package ahfe_pkg;

   localparam int STATION_W = 7;
   localparam int VALUE_W   = 24;
   localparam int CHAR_W    = 8;

   // Default number of frames that can wait between the front and back parts.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;  // ':'
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;  // '*'
   localparam logic [CHAR_W-1:0] TAG_SHORT  = 8'h53;  // 'S'
   localparam logic [CHAR_W-1:0] TAG_LONG   = 8'h50;  // 'P'

   localparam logic [3:0] POS_COLON      = 4'd0;
   localparam logic [3:0] POS_STATION    = 4'd1;
   localparam logic [3:0] POS_TAG        = 4'd2;
   localparam logic [3:0] POS_FIRST_DATA = 4'd3;
   localparam logic [3:0] DIGITS_SHORT   = 4'd4;
   localparam logic [3:0] DIGITS_LONG    = 4'd6;

   // One classified frame as it waits in the queue.
   typedef struct packed {
      logic [STATION_W-1:0] station;
      logic                 is_long;
      logic [VALUE_W-1:0]   data;
      logic [7:0]           checksum;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nibble);
      logic [CHAR_W-1:0] ch;
      if (nibble < 4'd10) begin
         ch = 8'h30 + {4'd0, nibble};
      end else begin
         ch = 8'h37 + {4'd0, nibble};
      end
      return ch;
   endfunction

endpackage

### design/ahfe_if.sv
interface ahfe_req_if;
   import ahfe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATION_W-1:0] station;
   logic [VALUE_W-1:0]   value;
   logic                 kind;

   modport source (output valid, output station, output value, output kind, input ready);
   modport sink   (input valid, input station, input value, input kind, output ready);
endinterface

interface ahfe_rsp_if;
   import ahfe_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

### design/ascii_hex_frame_encoder_core.sv
//  channel | dir | handshake             | payload
//  req     | in  | req_bus.valid/ready   | station[6:0], value[23:0], kind
//  rsp     | out | rsp_bus.valid/ready   | character[7:0], last
//
//  A short frame has 10 characters and a long frame 12, one character per cycle;
//  the back sequencer emitting one character per output transfer sets the rate.
//  Frames follow each other with no gap while requests keep arriving.
//  Reset is synchronous and empties the queue and the output register.
//  A stall on rsp holds the current character; req keeps being taken until
//  the queue is full.
module ascii_hex_frame_encoder_core #(
   parameter int QUEUE_DEPTH = ahfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ahfe_req_if.sink   req_bus,
   ahfe_rsp_if.source rsp_bus
);
   import ahfe_pkg::*;

   // The front part checks for room in the queue and classifies each request
   // transfer into a frame descriptor: tag choice and the full checksum are
   // worked out here, so the back part only has to pick characters.
   frame_type        push_frame;
   frame_type        head_frame;
   logic             push;
   logic             pop;
   queue_status_type queue_status;

   ahfe_front u_front (
      .req          (req_bus),
      .queue_status (queue_status),
      .push         (push),
      .frame        (push_frame)
   );

   // Short queue of descriptors, letting requests be taken while the back part
   // is still sending an earlier frame or is stalled by the consumer.
   ahfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_frame),
      .pop       (pop),
      .head      (head_frame),
      .status    (queue_status)
   );

   // The back part walks the head descriptor one character per transfer and
   // releases it on the closing '*', which carries the last flag.
   ahfe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head_frame),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp          (rsp_bus)
   );

endmodule

### design/ahfe_front.sv
module ahfe_front (
   ahfe_req_if.sink                 req,
   input  ahfe_pkg::queue_status_type queue_status,
   output logic                      push,
   output ahfe_pkg::frame_type       frame
);
   import ahfe_pkg::*;

   logic [CHAR_W-1:0] tag;
   logic [7:0]        sum;

   assign req.ready = !queue_status.full;
   assign push      = req.valid && !queue_status.full;

   assign tag = req.kind ? TAG_LONG : TAG_SHORT;

   // Checksum covers station, tag and every data digit; the high byte only
   // counts in a long frame.
   always_comb begin
      sum = {1'b0, req.station} + tag;
      for (int n = 0; n < 4; n++) begin
         sum = sum + hex_char(req.value[4*n +: 4]);
      end
      if (req.kind) begin
         sum = sum + hex_char(req.value[23:20]) + hex_char(req.value[19:16]);
      end
   end

   always_comb begin
      frame.station  = req.station;
      frame.is_long  = req.kind;
      frame.data     = req.value;
      frame.checksum = sum;
   end

endmodule

### design/ahfe_queue.sv
module ahfe_queue #(
   parameter int DEPTH = ahfe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ahfe_pkg::frame_type         push_data,
   input  logic                        pop,
   output ahfe_pkg::frame_type         head,
   output ahfe_pkg::queue_status_type  status
);
   import ahfe_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   frame_type        slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/ahfe_back.sv
module ahfe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ahfe_pkg::frame_type        head,
   input  ahfe_pkg::queue_status_type queue_status,
   output logic                       pop,
   ahfe_rsp_if.source                 rsp
);
   import ahfe_pkg::*;

   logic [3:0]        pos_ff, pos_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic              load;
   logic [3:0]        sum_pos;
   logic [3:0]        digit;
   logic [2:0]        digit_idx;
   logic [4:0]        bit_base;

   assign rsp.valid     = valid_ff;
   assign rsp.character = char_ff;
   assign rsp.last      = last_ff;

   // The output register takes a new character whenever it is empty or taken.
   assign load = !valid_ff || rsp.ready;

   assign sum_pos   = POS_FIRST_DATA + (head.is_long ? DIGITS_LONG : DIGITS_SHORT);
   assign digit_idx = 3'(pos_ff - POS_FIRST_DATA);
   // Bytes go low first, high nibble of each byte first.
   assign bit_base  = {digit_idx[2:1], ~digit_idx[0], 2'b00};
   assign digit     = head.data[bit_base +: 4];

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !queue_status.empty;
         if (!queue_status.empty) begin
            last_in = 1'b0;
            pos_in  = pos_ff + 1'b1;
            priority if (pos_ff == POS_COLON) begin
               char_in = CHAR_COLON;
            end else if (pos_ff == POS_STATION) begin
               char_in = {1'b0, head.station};
            end else if (pos_ff == POS_TAG) begin
               char_in = head.is_long ? TAG_LONG : TAG_SHORT;
            end else if (pos_ff < sum_pos) begin
               char_in = hex_char(digit);
            end else if (pos_ff == sum_pos) begin
               char_in = hex_char(head.checksum[7:4]);
            end else if (pos_ff == sum_pos + 4'd1) begin
               char_in = hex_char(head.checksum[3:0]);
            end else begin
               char_in = CHAR_STAR;
               last_in = 1'b1;
               pos_in  = POS_COLON;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_COLON;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

### test/ascii_hex_frame_encoder_core_tb.sv
`timescale 1ns / 100ps

module ascii_hex_frame_encoder_core_tb;
   import ahfe_pkg::*;

   // Frame kinds as carried in the kind field of a request.
   localparam logic KIND_SHORT = 1'b0;
   localparam logic KIND_LONG  = 1'b1;

   // Each side stalls in about this percentage of cycles, except inside the
   // quiet window, where both sides run flat out.
   localparam int IDLE_PERCENT = 8;
   localparam int QUIET_FROM   = 600;
   localparam int QUIET_UNTIL  = 1300;

   // Extra wait after the last predicted character, to catch any stray output.
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_FRAMES = 143;

   // One pending request. When hold_until_drained is set, the sender keeps the
   // channel idle until every character predicted so far has been received.
   typedef struct packed {
      logic [STATION_W-1:0] station;
      logic [VALUE_W-1:0]   value;
      logic                 kind;
      logic                 hold_until_drained;
   } frame_request_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } frame_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ahfe_req_if req_bus ();
   ahfe_rsp_if rsp_bus ();

   frame_request_type pending_requests[$];
   frame_char_type    expected_chars[$];
   int                error_count = 0;
   int                cycle_count = 0;

   ascii_hex_frame_encoder_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // A random stall decision for either side of the block.
   function automatic bit idle_now();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_UNTIL) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   // Uppercase ASCII hex digit for one nibble.
   function automatic logic [CHAR_W-1:0] ascii_hex_digit(input logic [3:0] nibble);
      if (nibble > 4'd9) begin
         return "A" + CHAR_W'(nibble - 4'd10);
      end
      return "0" + CHAR_W'(nibble);
   endfunction

   function automatic void expect_char(input logic [CHAR_W-1:0] character,
                                       input logic last);
      frame_char_type entry;
      entry.character = character;
      entry.last      = last;
      expected_chars.push_back(entry);
   endfunction

   // Builds the full character sequence of one frame. The checksum covers every
   // character after the colon up to the last data digit; a short frame sends
   // only the two low bytes, so value bits 23:16 never reach the line there.
   function automatic void predict_frame(input logic [STATION_W-1:0] station,
                                         input logic [VALUE_W-1:0] value,
                                         input logic kind);
      logic [7:0]        checksum;
      logic [CHAR_W-1:0] tag;
      logic [CHAR_W-1:0] high_digit;
      logic [CHAR_W-1:0] low_digit;
      logic [7:0]        data_byte;
      int                byte_count;
      int                idx;
      tag        = (kind == KIND_LONG) ? TAG_LONG : TAG_SHORT;
      byte_count = (kind == KIND_LONG) ? 3 : 2;
      expect_char(CHAR_COLON, 1'b0);
      expect_char({1'b0, station}, 1'b0);
      expect_char(tag, 1'b0);
      checksum = {1'b0, station} + tag;
      for (idx = 0; idx < byte_count; idx++) begin
         data_byte  = value[8*idx +: 8];
         high_digit = ascii_hex_digit(data_byte[7:4]);
         low_digit  = ascii_hex_digit(data_byte[3:0]);
         expect_char(high_digit, 1'b0);
         expect_char(low_digit, 1'b0);
         checksum = checksum + high_digit + low_digit;
      end
      expect_char(ascii_hex_digit(checksum[7:4]), 1'b0);
      expect_char(ascii_hex_digit(checksum[3:0]), 1'b0);
      expect_char(CHAR_STAR, 1'b1);
   endfunction

   function automatic void queue_frame(input logic [STATION_W-1:0] station,
                                       input logic [VALUE_W-1:0] value,
                                       input logic kind,
                                       input logic hold_until_drained);
      frame_request_type item;
      item.station            = station;
      item.value              = value;
      item.kind               = kind;
      item.hold_until_drained = hold_until_drained;
      pending_requests.push_back(item);
   endfunction

   // Request driver. The prediction is made at the edge where the transfer
   // happens, from the payload that is actually on the bus. A new item is only
   // presented when the channel is empty or its current item was just taken,
   // so valid stays high across back-to-back transfers with a single update.
   always @(posedge clock) begin : request_driver
      frame_request_type next_item;
      logic              present_next;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_frame(req_bus.station, req_bus.value, req_bus.kind);
         end
         if (!req_bus.valid || req_bus.ready) begin
            present_next = 1'b0;
            if (pending_requests.size() != 0 && !idle_now()) begin
               if (!pending_requests[0].hold_until_drained ||
                   expected_chars.size() == 0) begin
                  next_item       = pending_requests.pop_front();
                  present_next    = 1'b1;
                  req_bus.station <= next_item.station;
                  req_bus.value   <= next_item.value;
                  req_bus.kind    <= next_item.kind;
               end
            end
            req_bus.valid <= present_next;
         end
      end
   end

   // Character monitor. Every transfer on the result channel is checked
   // against the oldest predicted character, field by field.
   always @(posedge clock) begin : char_monitor
      frame_char_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character %h with last %b",
                      rsp_bus.character, rsp_bus.last);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_bus.character !== want.character) begin
                  $error("character mismatch: expected %h, got %h",
                         want.character, rsp_bus.character);
                  error_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last mismatch: expected %b, got %b",
                         want.last, rsp_bus.last);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= !idle_now();
      end
   end

   initial begin : stimulus
      logic [STATION_W-1:0] station;
      logic [VALUE_W-1:0]   value;
      int                   n;
      req_bus.valid   = 1'b0;
      req_bus.station = '0;
      req_bus.value   = '0;
      req_bus.kind    = KIND_SHORT;
      rsp_bus.ready   = 1'b0;

      // Directed frames: field extremes, both kinds, every hex digit, stations
      // that look like frame delimiters, and ignored upper bits of short frames.
      queue_frame(7'h00, 24'h000000, KIND_SHORT, 1'b0);
      queue_frame(7'h00, 24'h000000, KIND_LONG,  1'b0);
      queue_frame(7'h7F, 24'hFFFFFF, KIND_LONG,  1'b0);
      queue_frame(7'h7F, 24'hFFFFFF, KIND_SHORT, 1'b0);
      queue_frame(STATION_W'("A"), 24'h012345, KIND_LONG,  1'b0);
      queue_frame(STATION_W'("B"), 24'h6789AB, KIND_LONG,  1'b0);
      queue_frame(STATION_W'("C"), 24'hCDEF00, KIND_LONG,  1'b0);
      queue_frame(STATION_W'("D"), 24'hA5FEDC, KIND_SHORT, 1'b0);
      queue_frame(STATION_W'("D"), 24'h00FEDC, KIND_SHORT, 1'b0);
      queue_frame(7'h2A, 24'h123456, KIND_SHORT, 1'b0);
      queue_frame(7'h2A, 24'h123456, KIND_LONG,  1'b0);
      queue_frame(7'h3A, 24'h800001, KIND_LONG,  1'b1);
      queue_frame(STATION_W'("Z"), 24'hFF00FF, KIND_SHORT, 1'b0);
      queue_frame(STATION_W'("z"), 24'h00FF00, KIND_LONG,  1'b0);
      queue_frame(7'h55, 24'h555555, KIND_LONG,  1'b0);
      queue_frame(7'h2A, 24'hAAAAAA, KIND_SHORT, 1'b0);
      queue_frame(7'h40, 24'h999999, KIND_LONG,  1'b0);

      // Random frames, biased toward the corners of the value and station
      // ranges. One frame halfway through waits for the block to drain.
      for (n = 0; n < RANDOM_FRAMES; n++) begin
         case ($urandom_range(0, 7))
            0:       value = 24'h000000;
            1:       value = 24'hFFFFFF;
            2:       value = VALUE_W'($urandom & $urandom);
            3:       value = VALUE_W'($urandom | $urandom);
            default: value = VALUE_W'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       station = 7'h00;
            1:       station = 7'h7F;
            2:       station = STATION_W'("A" + $urandom_range(0, 25));
            default: station = STATION_W'($urandom_range(0, 127));
         endcase
         queue_frame(station, value, $urandom_range(0, 1) == 1,
                     n == RANDOM_FRAMES / 2);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken, then for every predicted
      // character, then a little longer to catch any stray output.
      while (pending_requests.size() != 0 || req_bus.valid) begin
         @(posedge clock);
      end
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("ascii_hex_frame_encoder_core_tb OK");
      end else begin
         $display("ascii_hex_frame_encoder_core_tb NOT OK");
      end
      $finish;
   end

   // Timeout with a wide margin over the length of the whole run.
   initial begin : watchdog
      #1000000;
      $display("ascii_hex_frame_encoder_core_tb NOT OK");
      $finish;
   end

endmodule

### filelist.f
design/ahfe_pkg.sv
design/ahfe_if.sv
design/ahfe_front.sv
design/ahfe_queue.sv
design/ahfe_back.sv
design/ascii_hex_frame_encoder_core.sv
test/ascii_hex_frame_encoder_core_tb.sv
